@@ hw/rtl/ccp_pkg.sv @@
// ccp_pkg: shared types, constants and codes for the cross-covariance block.
// Used by ccp_mac, ccp_store and cross_covariance_with_peak; no dependencies.
`timescale 1ns / 1ps

package ccp_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int SCALE_BITS     = 17;
    localparam int ENTRY_BITS     = 48;
    localparam int XS_BITS        = SAMPLE_BITS + SCALE_BITS + 1;
    localparam int PROD_BITS      = SAMPLE_BITS + XS_BITS;
    localparam int FRAC_SHIFT     = 16;
    localparam int DEF_MAX_Y_COLS = 16;
    localparam int DEF_MAX_X_COLS = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 17;

    localparam logic [SCALE_BITS-1:0] SCALE_ONE = 17'd65536;
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF = 50'sd32768;
    localparam logic signed [ENTRY_BITS:0] SUM_MAX = 49'sd140737488355327;
    localparam logic signed [ENTRY_BITS:0] SUM_MIN = -49'sd140737488355327;

    // item modes
    localparam logic [2:0] MODE_LOAD_Y = 3'd0;
    localparam logic [2:0] MODE_LOAD_X = 3'd1;
    localparam logic [2:0] MODE_FINISH = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_COLUMNS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_COLUMNS = 2'd2;

    typedef struct packed {
        logic [2:0]                    mode;
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last_in_row;
        logic [3:0]                    read_row;
        logic [5:0]                    read_col;
    } in_item_t;

    typedef struct packed {
        logic signed [ENTRY_BITS-1:0] result_value;
        logic                         is_peak;
    } out_item_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_SCALE,
        MAC_ENTRY
    } mac_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_XSCALE,
        ST_XACC,
        ST_XLAST,
        ST_SCAN,
        ST_SCANLAST,
        ST_READ,
        ST_READWAIT,
        ST_EMIT
    } state_t;

endpackage

@@ hw/rtl/ccp_mac.sv @@
// ccp_mac: shared multiplier with round, accumulate and saturate stage.
// Depends on ccp_pkg.
`timescale 1ns / 1ps

module ccp_mac
(
    input  logic                                  clk,
    input  ccp_pkg::mac_op_t                      op,
    input  logic signed [ccp_pkg::SAMPLE_BITS-1:0] a,
    input  logic [ccp_pkg::SCALE_BITS-1:0]        sc,
    input  logic signed [ccp_pkg::ENTRY_BITS-1:0] rd_data,
    output logic signed [ccp_pkg::ENTRY_BITS-1:0] wr_data
);

    logic signed [ccp_pkg::XS_BITS-1:0]   xs_reg;
    logic signed [ccp_pkg::PROD_BITS-1:0] prod_reg;
    logic signed [ccp_pkg::XS_BITS-1:0]   mult_b;
    logic signed [ccp_pkg::PROD_BITS-1:0] prod_full;
    logic signed [ccp_pkg::PROD_BITS-1:0] rnd;
    logic signed [ccp_pkg::PROD_BITS-1:0] term;
    logic signed [ccp_pkg::ENTRY_BITS:0]  sum;

    // one multiplier: x*scale first, then y*(x*scale) per entry
    assign mult_b    = (op == ccp_pkg::MAC_SCALE)
                     ? $signed({{(ccp_pkg::XS_BITS - ccp_pkg::SCALE_BITS){1'b0}}, sc})
                     : xs_reg;
    assign prod_full = a * mult_b;

    always_ff @(posedge clk)
    begin
        case (op)
            ccp_pkg::MAC_SCALE: xs_reg   <= prod_full[ccp_pkg::XS_BITS-1:0];
            ccp_pkg::MAC_ENTRY: prod_reg <= prod_full;
            default: ;
        endcase
    end

    // round half up, drop scale fraction, add, clamp symmetric
    assign rnd  = prod_reg + ccp_pkg::ROUND_HALF;
    assign term = rnd >>> ccp_pkg::FRAC_SHIFT;
    assign sum  = {rd_data[ccp_pkg::ENTRY_BITS-1], rd_data} + term[ccp_pkg::ENTRY_BITS:0];

    always_comb
    begin
        if (sum > ccp_pkg::SUM_MAX)
            wr_data = ccp_pkg::SUM_MAX[ccp_pkg::ENTRY_BITS-1:0];
        else if (sum < ccp_pkg::SUM_MIN)
            wr_data = ccp_pkg::SUM_MIN[ccp_pkg::ENTRY_BITS-1:0];
        else
            wr_data = sum[ccp_pkg::ENTRY_BITS-1:0];
    end

endmodule

@@ hw/rtl/ccp_store.sv @@
// ccp_store: covariance entry memory, one write port, one registered read port.
// Depends on ccp_pkg.
`timescale 1ns / 1ps

module ccp_store
#(
    parameter int AW = 10
)
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [ccp_pkg::ENTRY_BITS-1:0]    wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic [ccp_pkg::ENTRY_BITS-1:0]    rd_data
);

    logic [ccp_pkg::ENTRY_BITS-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/cross_covariance_with_peak.sv @@
// cross_covariance_with_peak: top level, sequencer, row buffer, peak scan, output reg.
// Depends on ccp_pkg, ccp_mac, ccp_store.
// Load y: ready stays high. Load x: ready again after scale, ny MACs and drain.
// Finish: scans ny*nx entries, one entry read a cycle. Read: READ, READWAIT, EMIT.
// Clear and reset: memory sweep of 2^AW entries (1024 at defaults), one entry a cycle.
// Rate is set by the single multiplier and the single memory read port.
`timescale 1ns / 1ps

module cross_covariance_with_peak
#(
    parameter int MAX_Y_COLS = ccp_pkg::DEF_MAX_Y_COLS,
    parameter int MAX_X_COLS = ccp_pkg::DEF_MAX_X_COLS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  ccp_pkg::in_item_t                    item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output ccp_pkg::out_item_t                   result,
    input  logic                                 cfg_wr_en,
    input  logic [ccp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ccp_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data
);

    localparam int YW  = (MAX_Y_COLS > 1) ? $clog2(MAX_Y_COLS) : 1;
    localparam int XW  = (MAX_X_COLS > 1) ? $clog2(MAX_X_COLS) : 1;
    localparam int AW  = YW + XW;
    localparam int YCW = $clog2(MAX_Y_COLS + 1);
    localparam int XCW = $clog2(MAX_X_COLS + 1);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    ccp_pkg::state_t state_reg, state_next;

    logic [ccp_pkg::SCALE_BITS-1:0] scale_reg;
    logic [4:0]                     ycols_reg;
    logic [6:0]                     xcols_reg;

    logic [YCW-1:0] y_index_reg;
    logic [XCW-1:0] x_index_reg;
    logic [YW-1:0]  i_reg;
    logic [XW-1:0]  j_reg;
    logic [XW-1:0]  col_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [AW-1:0]  p_addr_reg;
    logic           p_valid_reg;     // accumulate write pending
    logic           s_valid_reg;     // scan compare pending
    logic           out_valid_reg;

    ccp_pkg::in_item_t                    item_reg;
    ccp_pkg::out_item_t                   out_data_reg;
    logic signed [ccp_pkg::SAMPLE_BITS-1:0] ybuf_reg [MAX_Y_COLS];
    logic signed [ccp_pkg::ENTRY_BITS-1:0] acc_reg;  // peak or read value

    // ---------------------------------------------------------------
    // effective configuration: counts clamp to [1, max], scale to 1.0
    // ---------------------------------------------------------------
    logic [31:0]                    ny32, nx32;
    logic [YCW-1:0]                 ny;
    logic [XCW-1:0]                 nx;
    logic [ccp_pkg::SCALE_BITS-1:0] sc;

    always_comb
    begin
        if (ycols_reg == 5'd0)
            ny32 = 32'd1;
        else if (32'(ycols_reg) > MAX_Y_COLS)
            ny32 = 32'(MAX_Y_COLS);
        else
            ny32 = 32'(ycols_reg);
        if (xcols_reg == 7'd0)
            nx32 = 32'd1;
        else if (32'(xcols_reg) > MAX_X_COLS)
            nx32 = 32'(MAX_X_COLS);
        else
            nx32 = 32'(xcols_reg);
    end

    assign ny = ny32[YCW-1:0];
    assign nx = nx32[XCW-1:0];
    assign sc = (scale_reg > ccp_pkg::SCALE_ONE) ? ccp_pkg::SCALE_ONE : scale_reg;

    // ---------------------------------------------------------------
    // sequencing helpers
    // ---------------------------------------------------------------
    logic        accept;
    logic        i_last, j_last;
    logic        clr_last;
    logic        read_in_range;
    logic        emit_go;
    logic        x_active;
    logic [31:0] rrow32, rcol32;

    assign accept   = item_valid && item_ready;
    assign i_last   = (YCW'(i_reg) + YCW'(1)) == ny;
    assign j_last   = (XCW'(j_reg) + XCW'(1)) == nx;
    assign clr_last = &clr_cnt_reg;
    assign x_active = x_index_reg < nx;
    assign emit_go  = (state_reg == ccp_pkg::ST_EMIT) && (!out_valid_reg || result_ready);

    assign read_in_range = (32'(item.read_row) < MAX_Y_COLS)
                        && (32'(item.read_col) < MAX_X_COLS);
    assign rrow32 = 32'(item_reg.read_row);
    assign rcol32 = 32'(item_reg.read_col);

    // ---------------------------------------------------------------
    // shared datapath and store
    // ---------------------------------------------------------------
    ccp_pkg::mac_op_t                      mac_op;
    logic signed [ccp_pkg::SAMPLE_BITS-1:0] mac_a;
    logic signed [ccp_pkg::ENTRY_BITS-1:0] mac_wr_data;
    logic                                  rd_en, wr_en;
    logic [AW-1:0]                         rd_addr, wr_addr;
    logic [ccp_pkg::ENTRY_BITS-1:0]        wr_data;
    logic [ccp_pkg::ENTRY_BITS-1:0]        rd_data;
    logic signed [ccp_pkg::ENTRY_BITS-1:0] rd_signed;
    logic signed [ccp_pkg::ENTRY_BITS-1:0] rd_abs;

    assign rd_signed = $signed(rd_data);
    // stored entries never reach -2^47, so the magnitude always fits
    assign rd_abs    = rd_signed[ccp_pkg::ENTRY_BITS-1] ? -rd_signed : rd_signed;

    ccp_mac u_mac
    (
        .clk     (clk),
        .op      (mac_op),
        .a       (mac_a),
        .sc      (sc),
        .rd_data (rd_signed),
        .wr_data (mac_wr_data)
    );

    ccp_store #(
        .AW (AW)
    ) u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ccp_pkg::ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ccp_pkg::ST_IDLE;
            end
            ccp_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.mode)
                        ccp_pkg::MODE_LOAD_X:
                        begin
                            if (x_active)
                                state_next = ccp_pkg::ST_XSCALE;
                        end
                        ccp_pkg::MODE_FINISH: state_next = ccp_pkg::ST_SCAN;
                        ccp_pkg::MODE_READ:
                        begin
                            if (read_in_range)
                                state_next = ccp_pkg::ST_READ;
                            else
                                state_next = ccp_pkg::ST_EMIT;
                        end
                        ccp_pkg::MODE_CLEAR:  state_next = ccp_pkg::ST_CLEAR;
                        default: ;
                    endcase
                end
            end
            ccp_pkg::ST_XSCALE:   state_next = ccp_pkg::ST_XACC;
            ccp_pkg::ST_XACC:
            begin
                if (i_last)
                    state_next = ccp_pkg::ST_XLAST;
            end
            ccp_pkg::ST_XLAST:    state_next = ccp_pkg::ST_IDLE;
            ccp_pkg::ST_SCAN:
            begin
                if (i_last && j_last)
                    state_next = ccp_pkg::ST_SCANLAST;
            end
            ccp_pkg::ST_SCANLAST: state_next = ccp_pkg::ST_EMIT;
            ccp_pkg::ST_READ:     state_next = ccp_pkg::ST_READWAIT;
            ccp_pkg::ST_READWAIT: state_next = ccp_pkg::ST_EMIT;
            ccp_pkg::ST_EMIT:
            begin
                if (emit_go)
                    state_next = ccp_pkg::ST_IDLE;
            end
            default:              state_next = ccp_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        item_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = {i_reg, col_reg};
        mac_op     = ccp_pkg::MAC_HOLD;
        mac_a      = ybuf_reg[i_reg];
        // the accumulate write lands in the cycle after its read
        wr_en      = p_valid_reg;
        wr_addr    = p_addr_reg;
        wr_data    = mac_wr_data;
        case (state_reg)
            ccp_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            ccp_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            ccp_pkg::ST_XSCALE:
            begin
                mac_op = ccp_pkg::MAC_SCALE;
                mac_a  = item_reg.value;
            end
            ccp_pkg::ST_XACC:
            begin
                rd_en  = 1'b1;
                mac_op = ccp_pkg::MAC_ENTRY;
            end
            ccp_pkg::ST_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = {i_reg, j_reg};
            end
            ccp_pkg::ST_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = {rrow32[YW-1:0], rcol32[XW-1:0]};
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ccp_pkg::ST_CLEAR;
            scale_reg     <= ccp_pkg::SCALE_ONE;
            ycols_reg     <= 5'd16;
            xcols_reg     <= 7'd64;
            y_index_reg   <= '0;
            x_index_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            clr_cnt_reg   <= '0;
            p_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == ccp_pkg::ST_XACC);
            s_valid_reg <= (state_reg == ccp_pkg::ST_SCAN);

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    ccp_pkg::CFG_SCALE:     scale_reg <= cfg_wr_data[ccp_pkg::SCALE_BITS-1:0];
                    ccp_pkg::CFG_Y_COLUMNS: ycols_reg <= cfg_wr_data[4:0];
                    ccp_pkg::CFG_X_COLUMNS: xcols_reg <= cfg_wr_data[6:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                i_reg       <= '0;
                j_reg       <= '0;
                clr_cnt_reg <= '0;
                case (item.mode)
                    ccp_pkg::MODE_LOAD_Y:
                    begin
                        // index saturates at the buffer depth
                        if (y_index_reg < YCW'(MAX_Y_COLS))
                            y_index_reg <= y_index_reg + YCW'(1);
                    end
                    ccp_pkg::MODE_LOAD_X:
                    begin
                        if (item.last_in_row)
                        begin
                            x_index_reg <= '0;
                            y_index_reg <= '0;
                        end
                        else if (x_index_reg < XCW'(MAX_X_COLS))
                            x_index_reg <= x_index_reg + XCW'(1);
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                ccp_pkg::ST_CLEAR: clr_cnt_reg <= clr_cnt_reg + AW'(1);
                ccp_pkg::ST_XACC:  i_reg <= i_reg + YW'(1);
                ccp_pkg::ST_SCAN:
                begin
                    if (j_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + YW'(1);
                    end
                    else
                        j_reg <= j_reg + XW'(1);
                end
                default: ;
            endcase

            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            col_reg  <= x_index_reg[XW-1:0];
            // finish starts from zero; an out-of-range read returns zero
            acc_reg  <= '0;
            if (item.mode == ccp_pkg::MODE_LOAD_Y && y_index_reg < ny)
                ybuf_reg[y_index_reg[YW-1:0]] <= item.value;
        end

        if (state_reg == ccp_pkg::ST_XACC)
            p_addr_reg <= {i_reg, col_reg};

        if (s_valid_reg && (rd_abs > acc_reg))
            acc_reg <= rd_abs;

        if (state_reg == ccp_pkg::ST_READWAIT)
            acc_reg <= rd_signed;

        if (emit_go)
        begin
            out_data_reg.result_value <= acc_reg;
            out_data_reg.is_peak      <= (item_reg.mode == ccp_pkg::MODE_FINISH);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

@@ tb/cross_covariance_with_peak_tb.sv @@
// cross_covariance_with_peak_tb: self-checking bench for the cross-covariance block.
// Depends on ccp_pkg and the cross_covariance_with_peak RTL; a scoreboard class predicts
// each read and finish result; plain tasks drive items and config writes, an initial block the result stalls.
`timescale 1ns / 1ps

module cross_covariance_with_peak_tb;

    import ccp_pkg::*;

    // Number of covariance entries and the saturation bound of one entry.
    localparam int     ENTRY_COUNT  = DEF_MAX_Y_COLS * DEF_MAX_X_COLS;
    localparam longint ENTRY_LIMIT  = (longint'(1) << (ENTRY_BITS - 1)) - 1;

    // Mode codes the block ignores.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // Register values used for the out-of-range settings.
    localparam logic [CFG_DATA_BITS-1:0] SCALE_OVER = 17'h1FFFF;
    localparam int Y_COLS_OVER = 31;
    localparam int X_COLS_OVER = 127;

    // Cycles to let pass after the last result before touching config: covers the
    // store sweep of a clear plus the tail of an x load.
    localparam int SETTLE_CYCLES = ENTRY_COUNT + 64;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_AFTER  = 40;    // results taken before the long receiver hold
    localparam int HOLD_CYCLES = 2500;

    // ------------------------------------------------------------------
    // Covariance predictor and result checker
    // ------------------------------------------------------------------
    class cov_scoreboard;
        longint      cov_entry[ENTRY_COUNT];
        longint      y_row[DEF_MAX_Y_COLS];
        int unsigned y_pos;
        int unsigned x_pos;
        int unsigned scale_q16;
        int unsigned y_count;
        int unsigned x_count;
        out_item_t   expected_q[$];
        int          errors;

        function new();
            foreach (cov_entry[k]) cov_entry[k] = 0;
            foreach (y_row[k]) y_row[k] = 0;
            y_pos     = 0;
            x_pos     = 0;
            scale_q16 = SCALE_ONE;
            y_count   = DEF_MAX_Y_COLS;
            x_count   = DEF_MAX_X_COLS;
            errors    = 0;
        endfunction

        function int unsigned active_rows();
            if (y_count == 0) return 1;
            return (y_count > DEF_MAX_Y_COLS) ? DEF_MAX_Y_COLS : y_count;
        endfunction

        function int unsigned active_cols();
            if (x_count == 0) return 1;
            return (x_count > DEF_MAX_X_COLS) ? DEF_MAX_X_COLS : x_count;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_SCALE:     scale_q16 = data;
                CFG_Y_COLUMNS: y_count   = data[4:0];
                CFG_X_COLUMNS: x_count   = data[6:0];
                default: ;
            endcase
        endfunction

        function void note_item(in_item_t it);
            int unsigned ny;
            int unsigned nx;
            int unsigned addr;
            longint      sc;
            longint      samp;
            longint      sum;
            longint      peak;
            longint      mag;
            out_item_t   res;
            ny   = active_rows();
            nx   = active_cols();
            sc   = (scale_q16 > SCALE_ONE) ? longint'(SCALE_ONE) : longint'(scale_q16);
            samp = longint'($signed(it.value));
            case (it.mode)
                MODE_LOAD_Y:
                begin
                    if (y_pos < ny) y_row[y_pos] = samp;
                    if (y_pos < DEF_MAX_Y_COLS) y_pos++;
                end
                MODE_LOAD_X:
                begin
                    if (x_pos < nx)
                    begin
                        for (int i = 0; i < ny; i++)
                        begin
                            addr = i * DEF_MAX_X_COLS + x_pos;
                            // round half up, then floor by 2^16
                            sum = cov_entry[addr]
                                + ((y_row[i] * samp * sc + 32768) >>> FRAC_SHIFT);
                            if (sum > ENTRY_LIMIT) sum = ENTRY_LIMIT;
                            if (sum < -ENTRY_LIMIT) sum = -ENTRY_LIMIT;
                            cov_entry[addr] = sum;
                        end
                    end
                    if (x_pos < DEF_MAX_X_COLS) x_pos++;
                    if (it.last_in_row)
                    begin
                        x_pos = 0;
                        y_pos = 0;
                    end
                end
                MODE_FINISH:
                begin
                    peak = 0;
                    for (int i = 0; i < ny; i++)
                        for (int j = 0; j < nx; j++)
                        begin
                            mag = cov_entry[i * DEF_MAX_X_COLS + j];
                            if (mag < 0) mag = -mag;
                            if (mag > peak) peak = mag;
                        end
                    res.result_value = peak[ENTRY_BITS-1:0];
                    res.is_peak      = 1'b1;
                    expected_q = {expected_q, res};
                end
                MODE_READ:
                begin
                    addr = it.read_row * DEF_MAX_X_COLS + it.read_col;
                    mag  = cov_entry[addr];
                    res.result_value = mag[ENTRY_BITS-1:0];
                    res.is_peak      = 1'b0;
                    expected_q = {expected_q, res};
                end
                MODE_CLEAR:
                begin
                    foreach (cov_entry[k]) cov_entry[k] = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result item: result_value=%0d is_peak=%0b",
                       got.result_value, got.is_peak);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.result_value !== want.result_value)
            begin
                $error("result_value: expected %0d, actual %0d",
                       want.result_value, got.result_value);
                errors++;
            end
            if (got.is_peak !== want.is_peak)
            begin
                $error("is_peak: expected %0b, actual %0b", want.is_peak, got.is_peak);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_ready;
    in_item_t                  item;
    logic                      result_valid;
    logic                      result_ready;
    out_item_t                 result;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wr_data;

    cov_scoreboard board = new();

    // sender burst bookkeeping; valid_up mirrors what was last scheduled on item_valid
    int unsigned burst_left = 0;
    bit          valid_up   = 1'b0;

    cross_covariance_with_peak dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Item helpers
    // ------------------------------------------------------------------
    function automatic in_item_t make_item(logic [2:0] mode, logic [15:0] value,
                                           logic last, logic [3:0] row, logic [5:0] col);
        in_item_t it;
        it.mode        = mode;
        it.value       = value;
        it.last_in_row = last;
        it.read_row    = row;
        it.read_col    = col;
        return it;
    endfunction

    // Mostly uniform samples, with the full-scale corners mixed in.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until accepted. Bursts of random length are
    // separated by random gaps; long bursts give stretches with no idling.
    task automatic offer(input in_item_t it);
        int unsigned gap;
        item       <= it;
        item_valid <= 1'b1;
        valid_up    = 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        board.note_item(it);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            item_valid <= 1'b0;
            valid_up    = 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Sender pause: wait for every expected result, then for any result-less
    // work (clear sweep, x load tail) to finish inside the block.
    task automatic settle();
        if (valid_up)
        begin
            item_valid <= 1'b0;
            valid_up    = 1'b0;
        end
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges; only while idle.
    task automatic write_config(input logic [CFG_DATA_BITS-1:0] scale,
                                input int unsigned ycols, input int unsigned xcols);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SCALE;
        cfg_wr_data <= scale;
        board.set_reg(CFG_SCALE, scale);
        @(posedge clk);
        cfg_index   <= CFG_Y_COLUMNS;
        cfg_wr_data <= CFG_DATA_BITS'(ycols);
        board.set_reg(CFG_Y_COLUMNS, CFG_DATA_BITS'(ycols));
        @(posedge clk);
        cfg_index   <= CFG_X_COLUMNS;
        cfg_wr_data <= CFG_DATA_BITS'(xcols);
        board.set_reg(CFG_X_COLUMNS, CFG_DATA_BITS'(xcols));
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One sample row: y values, then x values with last_in_row on the final one.
    // The row length is usually the configured size, now and then short or long.
    task automatic send_row(output int unsigned sent);
        int unsigned ny;
        int unsigned nx;
        ny = board.active_rows();
        nx = board.active_cols();
        case ($urandom_range(0, 9))
            0: ny = ny + $urandom_range(1, 2);            // excess y values
            1: ny = $urandom_range(0, ny - 1);            // short y row, stale entries reused
            2: nx = nx + $urandom_range(1, 3);            // excess x values
            default: ;
        endcase
        for (int k = 0; k < ny; k++)
            offer(make_item(MODE_LOAD_Y, pick_sample(), 1'($urandom),
                            4'($urandom), 6'($urandom)));
        for (int k = 0; k < nx; k++)
            offer(make_item(MODE_LOAD_X, pick_sample(), k == nx - 1,
                            4'($urandom), 6'($urandom)));
        sent = ny + nx;
    endtask

    // Random traffic for one configuration: mostly well-formed rows with reads
    // and finishes in between, the rest loose loads, reads, ignored modes and clears.
    task automatic run_phase(input logic [CFG_DATA_BITS-1:0] scale,
                             input int unsigned ycols, input int unsigned xcols);
        int unsigned done;
        int unsigned sent;
        int unsigned pick;
        int unsigned kind;
        settle();
        write_config(scale, ycols, xcols);
        done = 0;
        while (done < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                send_row(sent);
                done += sent;
            end
            else if (pick < 75)
            begin
                // read inside the region in use
                offer(make_item(MODE_READ, 16'($urandom), 1'($urandom),
                                4'($urandom_range(0, board.active_rows() - 1)),
                                6'($urandom_range(0, board.active_cols() - 1))));
                done++;
            end
            else if (pick < 80)
            begin
                offer(make_item(MODE_FINISH, 16'($urandom), 1'($urandom),
                                4'($urandom), 6'($urandom)));
                done++;
            end
            else
            begin
                kind = $urandom_range(0, 99);
                if (kind < 35)
                    offer(make_item(MODE_LOAD_Y, pick_sample(), 1'($urandom),
                                    4'($urandom), 6'($urandom)));
                else if (kind < 70)
                    offer(make_item(MODE_LOAD_X, pick_sample(), 1'($urandom),
                                    4'($urandom), 6'($urandom)));
                else if (kind < 88)
                    offer(make_item(MODE_READ, 16'($urandom), 1'($urandom),
                                    4'($urandom), 6'($urandom)));
                else if (kind < 98)
                begin
                    // ignored modes do not count toward the phase
                    offer(make_item(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                                    16'($urandom), 1'($urandom), 4'($urandom), 6'($urandom)));
                    done--;
                end
                else
                    offer(make_item(MODE_CLEAR, 16'($urandom), 1'($urandom),
                                    4'($urandom), 6'($urandom)));
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: checks every accepted result item and stalls on its own
    // pattern, which rotates through four stall modes. Once, after HOLD_AFTER results,
    // it holds off for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned tick;
        int unsigned taken;
        int unsigned hold_left;
        bit          hold_done;
        tick         = 0;
        taken        = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                board.check_result(result);
                taken++;
            end
            tick++;
            if (!hold_done && taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case ((tick >> 8) % 4)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom);
                    2:       result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_BITS-1:0] scale;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_SCALE;
        cfg_wr_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings. A full row of y values comes first so
        // that no row buffer entry is read before it is written.
        offer(make_item(MODE_LOAD_Y, 16'h7FFF, 1'b1, 4'hF, 6'h3F));   // last ignored on y
        offer(make_item(MODE_LOAD_Y, 16'h8000, 1'b0, 4'h0, 6'h00));
        offer(make_item(MODE_LOAD_Y, 16'h0000, 1'b0, 4'h0, 6'h00));
        offer(make_item(MODE_LOAD_Y, 16'hFFFF, 1'b0, 4'h0, 6'h00));
        offer(make_item(MODE_LOAD_Y, 16'h0001, 1'b0, 4'h0, 6'h00));
        for (int k = 5; k < DEF_MAX_Y_COLS; k++)
            offer(make_item(MODE_LOAD_Y, pick_sample(), 1'b0, 4'h0, 6'h00));
        // short x row of corner values: max*max, min*min, then zero with row end
        offer(make_item(MODE_LOAD_X, 16'h7FFF, 1'b0, 4'h0, 6'h00));
        offer(make_item(MODE_LOAD_X, 16'h8000, 1'b0, 4'h0, 6'h00));
        offer(make_item(MODE_LOAD_X, 16'h0000, 1'b1, 4'h0, 6'h00));
        offer(make_item(MODE_READ,   16'h0000, 1'b0, 4'h0, 6'h00));
        offer(make_item(MODE_READ,   16'h0000, 1'b1, 4'h1, 6'h01));
        offer(make_item(MODE_READ,   16'h0000, 1'b0, 4'hF, 6'h3F));   // far corner
        offer(make_item(MODE_FINISH, 16'h0000, 1'b1, 4'h0, 6'h00));   // last ignored
        offer(make_item(MODE_SPARE_LO, 16'h1234, 1'b0, 4'h3, 6'h05));
        offer(make_item(MODE_SPARE_HI, 16'hFFFF, 1'b1, 4'hF, 6'h3F));
        offer(make_item(MODE_CLEAR,  16'h0000, 1'b0, 4'h0, 6'h00));
        offer(make_item(MODE_FINISH, 16'h0000, 1'b0, 4'h0, 6'h00));   // peak of a clean store
        offer(make_item(MODE_READ,   16'h0000, 1'b0, 4'h0, 6'h01));

        // Random phases: extremes and out-of-range register values first, then
        // mostly small random sizes so finishes stay short.
        for (int p = 0; p < PHASES; p++)
        begin
            scale = 17'($urandom_range(0, SCALE_ONE));
            case (p)
                0:       run_phase(SCALE_ONE, DEF_MAX_Y_COLS, DEF_MAX_X_COLS);
                1:       run_phase('0, 1, 1);
                2:       run_phase(SCALE_OVER, 0, 0);                  // act as 1.0, 1, 1
                3:       run_phase(17'($urandom), Y_COLS_OVER, X_COLS_OVER);
                4:       run_phase(scale, 1, DEF_MAX_X_COLS);
                5:       run_phase(scale, DEF_MAX_Y_COLS, 1);
                default: run_phase(scale, $urandom_range(1, 6), $urandom_range(1, 10));
            endcase
        end

        settle();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, well above the slowest legal run.
    initial
    begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_mac.sv
hw/rtl/ccp_store.sv
hw/rtl/cross_covariance_with_peak.sv
tb/cross_covariance_with_peak_tb.sv
